>>> src/ildr_pkg.sv
// Package for the indexed line doubler: geometry constants, command codes,
// queue entry types and the RGB565 packing function. No dependencies.
`default_nettype none

package ildr_pkg;

  // Source frame geometry and line layout
  localparam int SRC_WIDTH    = 256;
  localparam int SRC_HEIGHT   = 240;
  localparam int BORDER_WORDS = 32;
  localparam int SEG_WORDS    = 32;
  localparam int SEG_COUNT    = 16;
  localparam int LINE_LIMIT   = 480;
  localparam int STORE_DEPTH  = SRC_WIDTH * SRC_HEIGHT;
  localparam int PAL_DEPTH    = 256;

  // Derived widths
  localparam int FA_W    = $clog2(STORE_DEPTH);
  localparam int COL_W   = $clog2(SRC_WIDTH);
  localparam int K_W     = $clog2(SEG_WORDS);
  localparam int SEG_W   = $clog2(SEG_COUNT);
  localparam int WI_W    = K_W + SEG_W;
  localparam int PA_W    = $clog2(PAL_DEPTH);
  localparam int COLOR_W = 16;
  localparam int LINE_W  = 10;
  localparam int ROW_W   = LINE_W - 1;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes on the input port
  localparam logic [1:0] CMD_PAL_WRITE = 2'd0;
  localparam logic [1:0] CMD_PIX_WRITE = 2'd1;
  localparam logic [1:0] CMD_RENDER    = 2'd2;

  // Classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_PAL,
    OP_PIX,
    OP_RENDER
  } op_t;

  // One queue entry: address is the palette index, frame address or row base;
  // data is the packed color, pixel index or segment number
  typedef struct packed {
    op_t                op;
    logic [FA_W-1:0]    addr;
    logic [COLOR_W-1:0] data;
  } q_entry_t;

  // Front-to-queue push request
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } fe_push_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RENDER,
    BK_DRAIN
  } bk_state_t;

  // Pack 8-bit red, green, blue into RGB565
  function automatic logic [COLOR_W-1:0] pack_rgb565(input logic [7:0] r,
                                                      input logic [7:0] g,
                                                      input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

`default_nettype wire

>>> src/ildr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module ildr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/ildr_front.sv
// Front end: classifies each accepted command, drops those with no effect,
// and forms the queue entry. Depends on ildr_pkg.
`default_nettype none

module ildr_front
  import ildr_pkg::*;
(
  input  wire logic        start,
  input  wire logic        full,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  entry_index,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic [7:0]  pixel_x,
  input  wire logic [7:0]  pixel_y,
  input  wire logic [7:0]  pixel_value,
  input  wire logic [9:0]  out_line,
  input  wire logic [3:0]  segment,
  output fe_push_t         fe
);

  logic             pix_ok;
  logic [ROW_W-1:0] line_row;
  logic [ROW_W-1:0] src_row;
  logic             keep;
  q_entry_t         entry;

  // Range checks for pixel writes and source row selection for renders
  always_comb begin
    pix_ok   = ({1'b0, pixel_x} < 9'(SRC_WIDTH)) && ({1'b0, pixel_y} < 9'(SRC_HEIGHT));
    line_row = out_line[LINE_W-1:1];
    if ((out_line >= LINE_W'(LINE_LIMIT)) || (line_row >= ROW_W'(SRC_HEIGHT))) begin
      src_row = '0;
    end else begin
      src_row = line_row;
    end
  end

  // Build the entry for each command
  always_comb begin
    entry = '{op: OP_PAL, addr: '0, data: '0};
    keep  = 1'b0;
    unique case (command)
      CMD_PAL_WRITE: begin
        entry.op   = OP_PAL;
        entry.addr = FA_W'(entry_index);
        entry.data = pack_rgb565(red, green, blue);
        keep       = 1'b1;
      end
      CMD_PIX_WRITE: begin
        entry.op   = OP_PIX;
        entry.addr = FA_W'(pixel_y) * FA_W'(SRC_WIDTH) + FA_W'(pixel_x);
        entry.data = COLOR_W'(pixel_value);
        keep       = pix_ok;
      end
      CMD_RENDER: begin
        entry.op   = OP_RENDER;
        entry.addr = FA_W'(src_row) * FA_W'(SRC_WIDTH);
        entry.data = COLOR_W'(segment);
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign fe.push  = start && !full && keep;
  assign fe.entry = entry;

endmodule

`default_nettype wire

>>> src/ildr_queue.sv
// Short command queue between front and back end.
// Depends on ildr_pkg.
`default_nettype none

module ildr_queue
  import ildr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  fe_push_t   fe,
  input  wire logic  pop,
  output q_entry_t   head,
  output logic       empty,
  output logic       full
);

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count == '0);
  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push = fe.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= fe.entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/ildr_back.sv
// Back end: executes queued writes and streams render segments through the
// frame store and palette memories. Depends on ildr_pkg and ildr_ram.
`default_nettype none

module ildr_back
  import ildr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  q_entry_t         head,
  input  wire logic        empty,
  output logic             pop,
  output logic [31:0]      out_word,
  output logic             last,
  output logic             strobe
);

  bk_state_t          state;
  bk_state_t          state_next;
  logic [K_W-1:0]     k;
  logic [FA_W-1:0]    base;
  logic [SEG_W-1:0]   seg;
  logic               drain_cnt;

  logic               pal_we;
  logic               frm_we;
  logic               issue;

  logic [WI_W-1:0]    word_idx;
  logic               in_pix;
  logic [COL_W-1:0]   col;
  logic [FA_W-1:0]    frm_raddr;
  logic [7:0]         frm_rdata;
  logic [COLOR_W-1:0] pal_rdata;

  logic [PAL_DEPTH-1:0] pal_valid;

  logic               s1_v, s1_pix, s1_last;
  logic               s2_v, s2_pix, s2_last, s2_pv;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!empty && head.op == OP_RENDER) begin
          state_next = BK_RENDER;
        end
      end
      BK_RENDER: begin
        if (k == K_W'(SEG_WORDS - 1)) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (drain_cnt) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop    = (state == BK_IDLE) && !empty;
    pal_we = pop && (head.op == OP_PAL);
    frm_we = pop && (head.op == OP_PIX);
    issue  = (state == BK_RENDER);
  end

  // State and render counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      k         <= '0;
      drain_cnt <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && head.op == OP_RENDER) begin
        k <= '0;
      end else if (issue) begin
        k <= k + 1'b1;
      end
      drain_cnt <= (state == BK_DRAIN) ? !drain_cnt : 1'b0;
    end
  end

  // Latch render operands
  always_ff @(posedge clk) begin
    if (pop && head.op == OP_RENDER) begin
      base <= head.addr;
      seg  <= head.data[SEG_W-1:0];
    end
  end

  // Palette entries read as zero until written
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
    end else if (pal_we) begin
      pal_valid[head.addr[PA_W-1:0]] <= 1'b1;
    end
  end

  // Word position within the line and frame address
  always_comb begin
    word_idx  = {seg, k};
    in_pix    = (word_idx >= WI_W'(BORDER_WORDS)) &&
                (word_idx < WI_W'(BORDER_WORDS + SRC_WIDTH));
    col       = COL_W'(word_idx - WI_W'(BORDER_WORDS));
    frm_raddr = base + FA_W'(col);
  end

  ildr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (frm_we),
    .waddr (head.addr),
    .wdata (head.data[7:0]),
    .raddr (frm_raddr),
    .rdata (frm_rdata)
  );

  ildr_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (head.addr[PA_W-1:0]),
    .wdata (head.data),
    .raddr (frm_rdata),
    .rdata (pal_rdata)
  );

  // Pipeline control alongside the memory reads
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      s1_v   <= issue;
      s2_v   <= s1_v;
      strobe <= s2_v;
      last   <= s2_v && s2_last;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    s1_pix  <= in_pix;
    s1_last <= (k == K_W'(SEG_WORDS - 1));
    s2_pix  <= s1_pix;
    s2_last <= s1_last;
    s2_pv   <= pal_valid[frm_rdata];
    if (s2_v && s2_pix && s2_pv) begin
      out_word <= {pal_rdata, pal_rdata};
    end else begin
      out_word <= '0;
    end
  end

endmodule

`default_nettype wire

>>> src/indexed_line_doubler_rgb565_core.sv
// Indexed line doubler: palette write, pixel write and 32-word segment render.
// A render's first word passes the queue, the state register, the frame-store
// and palette reads and the output register. Writes go one per cycle while no
// render runs; a render makes 32 frame-store reads, one per cycle, then drains.
// busy is high while the 4-entry command queue is full; results cannot stall.
// Reset (rst, synchronous) empties the queue and makes every palette entry zero.
`default_nettype none

module indexed_line_doubler_rgb565_core
  import ildr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  entry_index,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic [7:0]  pixel_x,
  input  wire logic [7:0]  pixel_y,
  input  wire logic [7:0]  pixel_value,
  input  wire logic [9:0]  out_line,
  input  wire logic [3:0]  segment,
  output logic [31:0]      out_word,
  output logic             last,
  output logic             strobe
);

  fe_push_t fe;
  q_entry_t head;
  logic     empty;
  logic     full;
  logic     pop;

  assign busy = full;

  ildr_front u_front (
    .start       (start),
    .full        (full),
    .command     (command),
    .entry_index (entry_index),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_value (pixel_value),
    .out_line    (out_line),
    .segment     (segment),
    .fe          (fe)
  );

  ildr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .fe    (fe),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  ildr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word),
    .last     (last),
    .strobe   (strobe)
  );

endmodule

`default_nettype wire

>>> src/ildr_checker.sv
// Port-level checker for the indexed line doubler, bound to the top level.
// Depends on indexed_line_doubler_rgb565_core.
`default_nettype none

module ildr_assert_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic [31:0] out_word,
  input wire logic        last,
  input wire logic        strobe
);

  // Both halves of a result word carry the same color
  a_halves_equal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (out_word[31:16] == out_word[15:0]))
    else $error("result word halves differ");

  // last only marks a result
  a_last_with_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> strobe)
    else $error("last without strobe");

  // Words of a segment come back to back
  a_segment_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside a segment");

  // A segment end is followed by a gap before the next segment
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    last |=> !strobe)
    else $error("segment followed without gap");

endmodule

bind indexed_line_doubler_rgb565_core ildr_assert_checker u_ildr_checker (
  .clk      (clk),
  .rst      (rst),
  .out_word (out_word),
  .last     (last),
  .strobe   (strobe)
);

`default_nettype wire
